/* src/c3sa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c3sa_pkg
// shared types, constants and register indexes of the 3x3 convolution block
// ---------------------------------------------------------------------------
package c3sa_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 2048;
    localparam int unsigned KERNEL_SIZE_DEF = 3;
    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PIX_W = 24;
    localparam int unsigned SUM_W = 28;
    localparam int unsigned ACC_W = 32;
    localparam int unsigned COL_W = 11;
    localparam int unsigned ROW_W = 16;
    localparam logic signed [ACC_W-1:0] SUM_LIMIT = 32'sd75200265;

    localparam logic [CFG_IDX_W-1:0] REG_K_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_SCALE,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       capture;   // latch pixel, start line store read
        logic       shift;     // shift window, write line stores
        logic       mac_clr;
        logic       mac_en;
        logic [3:0] tap;
        logic       scale;
        logic       load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic has_result;
    } dp_sts_t;

endpackage
`default_nettype wire

/* src/c3sa_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c3sa_pix_if / c3sa_res_if
// valid/ready channels for input pixels and results
// ---------------------------------------------------------------------------
interface c3sa_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface c3sa_res_if;
    logic               valid;
    logic               ready;
    logic signed [27:0] red_sum;
    logic signed [27:0] green_sum;
    logic signed [27:0] blue_sum;
    logic [7:0]         red_byte;
    logic [7:0]         green_byte;
    logic [7:0]         blue_byte;
    logic               frame_end;
    modport source (output valid, red_sum, green_sum, blue_sum, red_byte, green_byte,
                    blue_byte, frame_end, input ready);
    modport sink (input valid, red_sum, green_sum, blue_sum, red_byte, green_byte,
                  blue_byte, frame_end, output ready);
endinterface
`default_nettype wire

/* src/c3sa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c3sa_ctrl
// sequencer: read line stores, nine multiply-accumulate steps, scale, output
// ---------------------------------------------------------------------------
module c3sa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             out_busy,
    input  wire c3sa_pkg::dp_sts_t sts,
    output c3sa_pkg::dp_cmd_t     cmd
);
    import c3sa_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] tap_reg, tap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.tap      = tap_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                // read data is registered now, window shifts this edge
                cmd.shift   = 1'b1;
                cmd.mac_clr = 1'b1;
                tap_next    = '0;
                state_next  = sts.has_result ? ST_MAC : ST_IDLE;
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                tap_next   = tap_reg + 4'd1;
                if (tap_reg == 4'd8)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/c3sa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c3sa_dp
// line stores, window, shared multiply-accumulate, scale-abs and output reg
// ---------------------------------------------------------------------------
module c3sa_dp #(
    parameter int unsigned MAX_WIDTH = c3sa_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [7:0]                    red_in,
    input  wire logic [7:0]                    green_in,
    input  wire logic [7:0]                    blue_in,
    input  wire logic [c3sa_pkg::CFG_DATA_W-1:0] k_top,
    input  wire logic [c3sa_pkg::CFG_DATA_W-1:0] k_mid,
    input  wire logic [c3sa_pkg::CFG_DATA_W-1:0] k_bot,
    input  wire logic [11:0]                   frame_width,
    input  wire logic [15:0]                   frame_height,
    input  wire logic signed [15:0]            scale_gain,
    input  wire logic signed [23:0]            scale_offset,
    input  wire c3sa_pkg::dp_cmd_t             cmd,
    output c3sa_pkg::dp_sts_t                  sts,
    c3sa_res_if.source                         res
);
    import c3sa_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = AW + 1;

    // line stores: never-written entries must read zero, so a per-line fill
    // count marks how far each store holds real data since reset
    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
    logic [PIX_W-1:0] upper_rd_reg, lower_rd_reg;
    logic [CW-1:0]    lower_fill_reg, upper_fill_reg;
    logic             upper_ok_reg, lower_ok_reg;

    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] win_reg [9];
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [AW-1:0]    addr_reg;
    logic             result_reg, last_reg;

    logic [CW-1:0] w_eff;
    logic [16:0]   h_eff;
    logic [AW-1:0] addr;
    logic          line_end, frame_last;

    always_comb
    begin
        if (frame_width < 12'd3)
            w_eff = CW'(3);
        else if (32'(frame_width) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(frame_width);
        h_eff      = (frame_height < 16'd3) ? 17'd3 : {1'b0, frame_height};
        addr       = (col_reg >= CW'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : col_reg[AW-1:0];
        line_end   = ({1'b0, col_reg} + 1'b1) >= {1'b0, w_eff};
        frame_last = line_end && (({1'b0, row_reg} + 17'd1) >= h_eff);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg      <= {blue_in, green_in, red_in};
            addr_reg     <= addr;
            upper_rd_reg <= upper_mem[addr];
            lower_rd_reg <= lower_mem[addr];
        end
        if (cmd.shift)
        begin
            upper_mem[addr_reg] <= lower_ok_reg ? lower_rd_reg : '0;
            lower_mem[addr_reg] <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            result_reg     <= 1'b0;
            last_reg       <= 1'b0;
            lower_fill_reg <= '0;
            upper_fill_reg <= '0;
            upper_ok_reg   <= 1'b0;
            lower_ok_reg   <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                upper_ok_reg <= {1'b0, addr} < upper_fill_reg;
                lower_ok_reg <= {1'b0, addr} < lower_fill_reg;
                result_reg   <= (col_reg >= CW'(2)) && (row_reg >= ROW_W'(2));
                last_reg     <= frame_last;
                if (line_end)
                begin
                    col_reg <= '0;
                    row_reg <= frame_last ? '0 : row_reg + 1'b1;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
            if (cmd.shift)
            begin
                // fill counts grow as addresses are first touched
                if ({1'b0, addr_reg} >= lower_fill_reg)
                    lower_fill_reg <= {1'b0, addr_reg} + 1'b1;
                if (({1'b0, addr_reg} >= upper_fill_reg) && lower_ok_reg)
                    upper_fill_reg <= {1'b0, addr_reg} + 1'b1;
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= upper_ok_reg ? upper_rd_reg : '0;
                win_reg[5] <= lower_ok_reg ? lower_rd_reg : '0;
                win_reg[8] <= pix_reg;
            end
        end
    end

    assign sts.has_result = result_reg;

    // shared multiply-accumulate, one tap per cycle for all three channels
    logic [CFG_DATA_W-1:0]   krow;
    logic signed [15:0]      coef;
    logic [PIX_W-1:0]        wpix;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] sum_sat [3];

    always_comb
    begin
        case (cmd.tap)
            4'd0, 4'd1, 4'd2: krow = k_top;
            4'd3, 4'd4, 4'd5: krow = k_mid;
            default:          krow = k_bot;
        endcase
        case (cmd.tap)
            4'd0, 4'd3, 4'd6: coef = signed'(krow[15:0]);
            4'd1, 4'd4, 4'd7: coef = signed'(krow[31:16]);
            default:          coef = signed'(krow[47:32]);
        endcase
        wpix = (cmd.tap < 4'd9) ? win_reg[cmd.tap] : '0;
        for (int c = 0; c < 3; c++)
        begin
            if (acc_reg[c] > SUM_LIMIT)
                sum_sat[c] = SUM_LIMIT;
            else if (acc_reg[c] < -SUM_LIMIT)
                sum_sat[c] = -SUM_LIMIT;
            else
                sum_sat[c] = acc_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.mac_clr)
                acc_reg[c] <= '0;
            else if (cmd.mac_en)
                acc_reg[c] <= acc_reg[c]
                            + ACC_W'(coef) * ACC_W'(signed'({1'b0, wpix[c*8 +: 8]}));
        end
    end

    // scale-abs: gain*sum + offset*1024, magnitude >> 18, clamp to 255
    logic signed [SUM_W-1:0] sum_reg [3];
    logic [7:0]              byte_reg [3];
    logic signed [43:0]      prod [3];
    logic signed [45:0]      lin [3];
    logic [45:0]             mag [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod[c] = scale_gain * SUM_W'(sum_sat[c]);
            lin[c]  = 46'(prod[c]) + {{12{scale_offset[23]}}, scale_offset, 10'd0};
            mag[c]  = lin[c][45] ? 46'(-lin[c]) : 46'(lin[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c]  <= SUM_W'(sum_sat[c]);
                byte_reg[c] <= (mag[c][45:18] > 28'd255) ? 8'd255 : mag[c][25:18];
            end
        end
    end

    // output register
    logic                    ov_reg;
    logic signed [SUM_W-1:0] osum_reg [3];
    logic [7:0]              obyte_reg [3];
    logic                    oend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.load_out)
            ov_reg <= 1'b1;
        else if (res.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            osum_reg  <= sum_reg;
            obyte_reg <= byte_reg;
            oend_reg  <= last_reg;
        end
    end

    assign res.valid      = ov_reg;
    assign res.red_sum    = osum_reg[0];
    assign res.green_sum  = osum_reg[1];
    assign res.blue_sum   = osum_reg[2];
    assign res.red_byte   = obyte_reg[0];
    assign res.green_byte = obyte_reg[1];
    assign res.blue_byte  = obyte_reg[2];
    assign res.frame_end  = oend_reg;

endmodule
`default_nettype wire

/* src/conv3x3_scale_abs_rgb.sv */
`timescale 1ns / 1ps
`default_nettype none
// a pixel with no result goes from idle through the read state back to idle; one with a
//   result then steps through nine mac taps, scale and output; no new pixel enters until
//   it is done, set by the single shared multiply-accumulate stepping through the nine taps
// the output register lets the next pixel enter while a result waits to be taken
// reset: asynchronous, active low; control, window and config registers return to defaults,
//   line stores read as zero through fill counts, so no clearing pass is needed
// ---------------------------------------------------------------------------
// conv3x3_scale_abs_rgb
// valid-mode 3x3 correlation on rgb pixels followed by scale-abs to bytes
// ---------------------------------------------------------------------------
module conv3x3_scale_abs_rgb #(
    parameter int unsigned MAX_WIDTH   = c3sa_pkg::MAX_WIDTH_DEF,
    parameter int unsigned KERNEL_SIZE = c3sa_pkg::KERNEL_SIZE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [c3sa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [c3sa_pkg::CFG_DATA_W-1:0] cfg_data,
    c3sa_pix_if.sink                             pix,
    c3sa_res_if.source                           res
);
    import c3sa_pkg::*;

    logic [CFG_DATA_W-1:0] k_top_reg, k_mid_reg, k_bot_reg;
    logic [11:0]           width_reg;
    logic [15:0]           height_reg;
    logic signed [15:0]    gain_reg;
    logic signed [23:0]    offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_top_reg  <= '0;
            k_mid_reg  <= '0;
            k_bot_reg  <= '0;
            width_reg  <= 12'd640;
            height_reg <= 16'd480;
            gain_reg   <= 16'sd256;
            offset_reg <= '0;
        end
        else if (cfg_we && KERNEL_SIZE == 3)
        begin
            case (cfg_index)
                REG_K_TOP:  k_top_reg  <= cfg_data;
                REG_K_MID:  k_mid_reg  <= cfg_data;
                REG_K_BOT:  k_bot_reg  <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data[11:0];
                REG_HEIGHT: height_reg <= cfg_data[15:0];
                REG_GAIN:   gain_reg   <= signed'(cfg_data[15:0]);
                REG_OFFSET: offset_reg <= signed'(cfg_data[23:0]);
                default:    ;
            endcase
        end
    end

    dp_cmd_t cmd;
    dp_sts_t sts;

    c3sa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_ready (pix.ready),
        .out_busy (res.valid && !res.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    c3sa_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .red_in       (pix.red_in),
        .green_in     (pix.green_in),
        .blue_in      (pix.blue_in),
        .k_top        (k_top_reg),
        .k_mid        (k_mid_reg),
        .k_bot        (k_bot_reg),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .scale_gain   (gain_reg),
        .scale_offset (offset_reg),
        .cmd          (cmd),
        .sts          (sts),
        .res          (res)
    );

endmodule
`default_nettype wire

/* src/c3sa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c3sa_checker
// port-level checks of the pixel and result channels, bound to the top level
// ---------------------------------------------------------------------------
module c3sa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red_byte,
    input wire logic       frame_end
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_byte) && $stable(frame_end))
        else $error("result changed while stalled");

    // the controller leaves idle on each accepted pixel, so ready drops after a transaction
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("pixel accepted back to back");

    // a result needs the full mac sequence after its pixel
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!(in_valid && in_ready), 1))
        else $error("result appeared too soon after a pixel");

endmodule

bind conv3x3_scale_abs_rgb c3sa_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .red_byte  (res.red_byte),
    .frame_end (res.frame_end)
);
`default_nettype wire

/* verif/conv_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conv_checker
// watches the pixel and result channels, predicts each windowed result of the
// 3x3 correlation and scale-abs conversion, and counts mismatches
// ---------------------------------------------------------------------------
module conv_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [c3sa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c3sa_pkg::CFG_DATA_W-1:0]   cfg_data,
    c3sa_pix_if                               pix,
    c3sa_res_if                               res,
    output int                                mismatch_count,
    output int                                pending_count,
    output int                                result_count
);
    import c3sa_pkg::*;

    localparam int MAXW = 2048;
    localparam int LIMIT = 75200265;

    typedef struct packed {
        logic [27:0] rs;
        logic [27:0] gs;
        logic [27:0] bs;
        logic [7:0]  rb;
        logic [7:0]  gb;
        logic [7:0]  bb;
        logic        fe;
    } conv_result_t;

    conv_result_t expected_results[$];

    logic [47:0] krow [3];
    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [15:0] gain_reg;
    logic [23:0] offset_reg;
    logic [23:0] upper_line [MAXW];
    logic [23:0] lower_line [MAXW];
    logic [23:0] win [9];
    int unsigned col_pos;
    int unsigned row_pos;

    function automatic longint window_sum(int sh);
        longint acc;
        logic signed [15:0] k;
        acc = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                k = krow[r][16*c +: 16];
                acc += longint'(k) * longint'((win[r*3+c] >> sh) & 8'hFF);
            end
        if (acc > LIMIT) acc = LIMIT;
        if (acc < -LIMIT) acc = -LIMIT;
        return acc;
    endfunction

    function automatic logic [7:0] scaled_byte(longint s);
        longint v;
        longint g;
        longint o;
        g = longint'($signed(gain_reg));
        o = longint'($signed(offset_reg));
        v = g * s + o * 1024;
        if (v < 0) v = -v;
        v = v >>> 18;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    task automatic predict_pixel(logic [23:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        bit line_end;
        bit frame_last;
        longint s0;
        longint s1;
        longint s2;
        conv_result_t e;
        w = width_reg; h = height_reg;
        if (w < 3) w = 3;
        if (w > MAXW) w = MAXW;
        if (h < 3) h = 3;
        c = (col_pos >= MAXW) ? MAXW - 1 : col_pos;
        for (int r = 0; r < 3; r++)
        begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = upper_line[c];
        win[5] = lower_line[c];
        win[8] = p;
        upper_line[c] = lower_line[c];
        lower_line[c] = p;
        line_end = (col_pos + 1 >= w);
        frame_last = line_end && (row_pos + 1 >= h);
        if (col_pos >= 2 && row_pos >= 2)
        begin
            s0 = window_sum(0); s1 = window_sum(8); s2 = window_sum(16);
            e.rs = s0[27:0]; e.gs = s1[27:0]; e.bs = s2[27:0];
            e.rb = scaled_byte(s0); e.gb = scaled_byte(s1); e.bb = scaled_byte(s2);
            e.fe = frame_last;
            expected_results.push_back(e);
        end
        if (line_end)
        begin
            col_pos = 0;
            row_pos = frame_last ? 0 : ((row_pos + 1) & 16'hFFFF);
        end
        else
            col_pos++;
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        conv_result_t e;
        conv_result_t a;
        if (!rst_n)
        begin
            krow[0] = '0; krow[1] = '0; krow[2] = '0;
            width_reg = 640; height_reg = 480; gain_reg = 256; offset_reg = '0;
            for (int i = 0; i < MAXW; i++)
            begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            for (int i = 0; i < 9; i++) win[i] = '0;
            col_pos = 0; row_pos = 0;
            mismatch_count = 0; result_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_K_TOP:  krow[0] = cfg_data;
                    REG_K_MID:  krow[1] = cfg_data;
                    REG_K_BOT:  krow[2] = cfg_data;
                    REG_WIDTH:  width_reg = cfg_data[11:0];
                    REG_HEIGHT: height_reg = cfg_data[15:0];
                    REG_GAIN:   gain_reg = cfg_data[15:0];
                    REG_OFFSET: offset_reg = cfg_data[23:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
                predict_pixel({pix.blue_in, pix.green_in, pix.red_in});
            if (res.valid && res.ready)
            begin
                result_count++;
                a = {res.red_sum, res.green_sum, res.blue_sum, res.red_byte,
                     res.green_byte, res.blue_byte, res.frame_end};
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result transaction %h", $time, a);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (a !== e)
                    begin
                        mismatch_count++;
                        $display("%0t: mismatch expected %h actual %h", $time, e, a);
                    end
                end
            end
        end
    end
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// streams directed and random frames through the 3x3 convolution block under
// several kernel, geometry and scale settings with random flow control
// ---------------------------------------------------------------------------
module tb_top;
    import c3sa_pkg::*;

    // index past the last register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_K_TOP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int mismatch_count;
    int pending_count;
    int result_count;
    int send_idle = 0;
    int recv_idle = 0;
    int pixels_sent = 0;
    longint cycle_count = 0;

    c3sa_pix_if pix ();
    c3sa_res_if res ();

    always #2 clk = ~clk;

    conv3x3_scale_abs_rgb DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pix(pix.sink), .res(res.source)
    );

    conv_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pix(pix), .res(res),
        .mismatch_count(mismatch_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    initial
    begin
        pix.valid = 0; pix.red_in = 0; pix.green_in = 0; pix.blue_in = 0;
        res.ready = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
        res.ready <= rst_n && ($urandom_range(99) >= recv_idle);

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic wait_drained();
        while (pending_count != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // drive one pixel; the valid stays high across back-to-back transactions
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            pix.valid <= 0;
            @(negedge clk);
        end
        pix.valid <= 1; pix.red_in <= r; pix.green_in <= g; pix.blue_in <= b;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic idle_sender();
        pix.valid <= 0;
        @(negedge clk);
    endtask

    function automatic logic [47:0] random_row(int mode);
        logic [47:0] v;
        for (int c = 0; c < 3; c++)
            case (mode)
                0: v[16*c +: 16] = $urandom;
                1: v[16*c +: 16] = 16'sd1024 >>> $urandom_range(3);
                default: v[16*c +: 16] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            endcase
        return v;
    endfunction

    task automatic send_frame(int w, int h, int pmode);
        for (int i = 0; i < w * h; i++)
            case (pmode)
                0: send_pixel($urandom, $urandom, $urandom);
                1: send_pixel(8'hFF, 8'hFF, 8'hFF);
                default: send_pixel($urandom_range(1) ? 8'hFF : 8'h00,
                                    $urandom_range(1) ? 8'hFF : 8'h00, $urandom);
            endcase
        idle_sender();
    endtask

    initial
    begin
        int w;
        int h;
        repeat (10) @(negedge clk);
        rst_n = 1;

        // directed: extremes of kernel, gain and offset on tiny frames
        write_reg(REG_WIDTH, 3); write_reg(REG_HEIGHT, 3);
        send_frame(3, 3, 1);                      // reset kernel gives zeros
        idle_sender(); wait_drained();
        write_reg(REG_K_TOP, {3{16'h8000}});
        write_reg(REG_K_MID, {3{16'h8000}});
        write_reg(REG_K_BOT, {3{16'h8000}});      // most negative, saturates sum
        write_reg(REG_GAIN, 16'h8000);
        write_reg(REG_OFFSET, 24'h7FFFFF);
        send_frame(3, 3, 1);
        wait_drained();
        write_reg(REG_K_TOP, {3{16'h7FFF}});
        write_reg(REG_K_MID, {3{16'h7FFF}});
        write_reg(REG_K_BOT, {3{16'h7FFF}});
        write_reg(REG_GAIN, 16'h7FFF);
        write_reg(REG_OFFSET, 24'h800000);
        send_frame(3, 3, 2);
        wait_drained();
        // out-of-range geometry and unused register index
        write_reg(REG_WIDTH, 0); write_reg(REG_HEIGHT, 1);
        write_reg(REG_UNUSED, '1);
        send_frame(3, 3, 0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 37 : (phase == 1) ? 66 : 0;
            recv_idle = (phase == 0) ? 66 : (phase == 1) ? 37 : 0;
            for (int f = 0; f < 3; f++)
            begin
                wait_drained();
                for (int r = 0; r < 3; r++)
                    write_reg(REG_K_TOP + 3'(r), random_row(f % 3));
                write_reg(REG_GAIN, (f % 2) ? $urandom : 16'd256 >> $urandom_range(4));
                write_reg(REG_OFFSET, (f % 3 == 0) ? $urandom : $urandom_range(4096));
                w = $urandom_range(3, 10); h = $urandom_range(3, 8);
                write_reg(REG_WIDTH, w); write_reg(REG_HEIGHT, h);
                send_frame(w, h, f % 3 == 2 ? 2 : 0);
            end
        end
        // one line at the widest clamp, then a small frame continuing from it
        wait_drained();
        write_reg(REG_WIDTH, 4095); write_reg(REG_HEIGHT, 3);
        send_frame(2048, 1, 0);
        wait_drained();
        write_reg(REG_WIDTH, 3); write_reg(REG_HEIGHT, 3);
        send_frame(3, 3, 0);
        // mid-frame geometry change
        wait_drained();
        write_reg(REG_WIDTH, 8); write_reg(REG_HEIGHT, 8);
        send_frame(5, 4, 0);
        wait_drained();
        write_reg(REG_WIDTH, 4); write_reg(REG_HEIGHT, 3);
        send_frame(8, 4, 0);

        wait_drained();
        $display("sent %0d pixels, checked %0d results over kernel, scale and geometry sweeps",
                 pixels_sent, result_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
